// ===== hw/rtl/utf8_to_utf16_decoder_core_defines.svh =====
// Assertion macros used by the decoder back end.
`ifndef UTF8_TO_UTF16_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_CORE_DEFINES_SVH

// Concurrent check on the rising clock edge, held off while reset is low.
`define U8U16_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Concurrent check: the consequent must hold in the cycle after the antecedent.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/u8u16_pkg.sv =====
// Types and constants of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam int BYTE_W    = 8;
    localparam int UNIT_W    = 16;
    localparam int PEND_W    = 2;
    localparam int ACC_W     = 21;
    localparam int CONT_BITS = 6;

    localparam logic [UNIT_W-1:0] REPL_UNIT  = 16'hFFFD;
    localparam logic [BYTE_W-1:0] ASCII_END  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_END   = 8'hF5;
    localparam logic [1:0]        CONT_TAG   = 2'b10;

    // Job queue between front and back; depth must be a power of two.
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // Units produced by one byte: one or two, in order.
    typedef struct packed {
        logic              two_units;
        logic [UNIT_W-1:0] unit0;
        logic [UNIT_W-1:0] unit1;
        logic              last;
    } t_job;

endpackage

// ===== hw/rtl/u8u16_in_if.sv =====
// Byte channel into the decoder.
interface u8u16_in_if;
    import u8u16_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] utf8_byte;
    logic              end_of_text;

    modport source (output valid, output utf8_byte, output end_of_text, input ready);
    modport sink   (input valid, input utf8_byte, input end_of_text, output ready);
endinterface

// ===== hw/rtl/u8u16_out_if.sv =====
// Code unit channel out of the decoder.
interface u8u16_out_if;
    import u8u16_pkg::*;

    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] utf16_unit;
    logic              last_unit;

    modport source (output valid, output utf16_unit, output last_unit, input ready);
    modport sink   (input valid, input utf16_unit, input last_unit, output ready);
endinterface

// ===== hw/rtl/utf8_to_utf16_decoder_core.sv =====
// Top level of the UTF-8 to UTF-16 (Basic Multilingual Plane) decoder.
// The core takes one UTF-8 byte per word on i_in and delivers UTF-16 code
// units, one per word, on o_out. While o_out is ready, the core sustains one
// byte per cycle for as long as each byte yields at most one unit; a byte
// that yields two units (a bad continuation, whose 0xFFFD is followed by the
// unit of the same byte read again as a lead, or by a second 0xFFFD when that
// byte opens a sequence that end of text cuts short) holds the output register
// for both words, since the back end moves one word per cycle while o_out is
// ready. Bytes that only open or extend a sequence give no word. Invalid lead
// bytes, bad continuations, code points above U+FFFF and sequences cut off by
// end_of_text each give 0xFFFD; overlong forms and surrogates pass unchecked.
// The word that closes a text carries last_unit. A byte's first unit goes
// through the job queue, then the output register. Internally, a front end
// classifies bytes, a two-entry job queue decouples it, and a back end plays
// the jobs out, so input and output stall independently.
module utf8_to_utf16_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16_in_if.sink    i_in,
    u8u16_out_if.source o_out
);
    import u8u16_pkg::*;

    logic q_ready;
    logic q_push;
    t_job q_wr_job;
    logic q_valid;
    t_job q_rd_job;
    logic q_pop;

    // Classify each byte and hold the sequence state.
    u8u16_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_queue_ready (q_ready),
        .o_push        (q_push),
        .o_job         (q_wr_job)
    );

    // Hold jobs while the output side stalls.
    u8u16_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_wr_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_rd_job),
        .i_pop   (q_pop)
    );

    // Advance jobs to the output register one word at a time.
    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_rd_job),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

// ===== hw/rtl/u8u16_front.sv =====
// Front end: accepts bytes, tracks the sequence state and forms unit jobs.
module u8u16_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    u8u16_in_if.sink        i_in,
    input  logic            i_queue_ready,
    output logic            o_push,
    output u8u16_pkg::t_job o_job
);
    import u8u16_pkg::*;

    logic [PEND_W-1:0] r_pend, n_pend;
    logic [ACC_W-1:0]  r_acc, n_acc;

    logic [BYTE_W-1:0] b;
    logic [ACC_W-1:0]  acc_sh;
    logic              do_lead;
    logic              lead_emit;
    logic [UNIT_W-1:0] lead_unit;
    logic [1:0]        cnt;
    logic [UNIT_W-1:0] u0, u1;
    logic              accept;

    assign b      = i_in.utf8_byte;
    assign acc_sh = {r_acc[ACC_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};

    always_comb begin
        n_pend    = r_pend;
        n_acc     = r_acc;
        cnt       = 2'd0;
        u0        = REPL_UNIT;
        u1        = REPL_UNIT;
        do_lead   = 1'b0;
        lead_emit = 1'b0;
        lead_unit = REPL_UNIT;

        if (r_pend == '0) begin
            do_lead = 1'b1;
        end else if (b[7:6] == CONT_TAG) begin
            n_pend = r_pend - PEND_W'(1);
            n_acc  = acc_sh;
            if (n_pend == '0) begin
                u0    = (acc_sh[ACC_W-1:UNIT_W] == '0) ? acc_sh[UNIT_W-1:0] : REPL_UNIT;
                cnt   = 2'd1;
                n_acc = '0;
            end
        end else begin
            // Bad continuation: drop the sequence, then decode as a lead.
            u0      = REPL_UNIT;
            cnt     = 2'd1;
            n_pend  = '0;
            n_acc   = '0;
            do_lead = 1'b1;
        end

        if (do_lead) begin
            priority if (b < ASCII_END) begin
                lead_emit = 1'b1;
                lead_unit = {{(UNIT_W-BYTE_W){1'b0}}, b};
            end else if (b < LEAD2_MIN) begin
                lead_emit = 1'b1;
            end else if (b < LEAD3_MIN) begin
                n_pend = PEND_W'(1);
                n_acc  = {{(ACC_W-5){1'b0}}, b[4:0]};
            end else if (b < LEAD4_MIN) begin
                n_pend = PEND_W'(2);
                n_acc  = {{(ACC_W-4){1'b0}}, b[3:0]};
            end else if (b < LEAD_END) begin
                n_pend = PEND_W'(3);
                n_acc  = {{(ACC_W-3){1'b0}}, b[2:0]};
            end else begin
                lead_emit = 1'b1;
            end
        end

        if (lead_emit) begin
            if (cnt == 2'd0) begin
                u0 = lead_unit;
            end else begin
                u1 = lead_unit;
            end
            cnt = cnt + 2'd1;
        end

        // Text ends inside a sequence: flag it and return to rest.
        if (i_in.end_of_text && (n_pend != '0)) begin
            if (cnt == 2'd0) begin
                u0 = REPL_UNIT;
            end else begin
                u1 = REPL_UNIT;
            end
            cnt    = cnt + 2'd1;
            n_pend = '0;
            n_acc  = '0;
        end
    end

    assign i_in.ready = i_queue_ready;
    assign accept     = i_in.valid && i_queue_ready;
    assign o_push     = accept && (cnt != 2'd0);

    always_comb begin
        o_job.two_units = (cnt == 2'd2);
        o_job.unit0     = u0;
        o_job.unit1     = u1;
        o_job.last      = i_in.end_of_text;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_acc  <= '0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
        end
    end

endmodule

// ===== hw/rtl/u8u16_fifo.sv =====
// Short job queue between front and back end.
module u8u16_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8u16_pkg::t_job i_job,
    output logic            o_ready,
    output logic            o_valid,
    output u8u16_pkg::t_job o_job,
    input  logic            i_pop
);
    import u8u16_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count;

    assign o_ready = (r_count != JOB_CNT_W'(JOB_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + JOB_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + JOB_PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + JOB_CNT_W'(1);
                2'b01:   r_count <= r_count - JOB_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/u8u16_back.sv =====
// Back end: plays each job out as one or two words on the output register.
`include "utf8_to_utf16_decoder_core_defines.svh"

module u8u16_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  u8u16_pkg::t_job i_job,
    output logic            o_pop,
    u8u16_out_if.source     o_out
);
    import u8u16_pkg::*;

    logic              r_valid;
    logic [UNIT_W-1:0] r_unit;
    logic              r_out_last;
    logic              r_second;
    logic [UNIT_W-1:0] r_unit1;
    logic              r_job_last;

    logic take;
    logic free;

    assign o_out.valid      = r_valid;
    assign o_out.utf16_unit = r_unit;
    assign o_out.last_unit  = r_out_last;

    assign take  = r_valid && o_out.ready;
    assign free  = !r_valid || take;
    assign o_pop = free && !r_second && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (free) begin
            if (r_second) begin
                r_valid  <= 1'b1;
                r_second <= 1'b0;
            end else begin
                r_valid  <= i_job_valid;
                r_second <= i_job_valid && i_job.two_units;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free) begin
            if (r_second) begin
                r_unit     <= r_unit1;
                r_out_last <= r_job_last;
            end else if (i_job_valid) begin
                r_unit     <= i_job.unit0;
                r_out_last <= i_job.last && !i_job.two_units;
                r_unit1    <= i_job.unit1;
                r_job_last <= i_job.last;
            end
        end
    end

    `U8U16_ASSERT(a_second_needs_first, !r_second || r_valid, "second word pending without first")
    `U8U16_ASSERT(a_first_not_last, !r_second || !r_out_last, "first of a pair flagged last")
    `U8U16_ASSERT(a_pop_when_free, !o_pop || free, "job taken while output busy")
    `U8U16_ASSERT_NEXT(a_pair_follows, take && r_second, r_valid, "second word of pair lost")

endmodule
